// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked implication on clk, off while rst is high.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tlb_pkg.sv =====
// Package: shared constants and structs of the translation buffer.
`timescale 1ns / 1ps
`default_nettype none
package tlb_pkg;

  localparam int ENTRIES_DEF   = 16;
  localparam int PAGE_BITS_DEF = 20;
  localparam int STAMP_BITS    = 32;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  // Victim-search token handed from cell to cell.
  typedef struct packed {
    logic valid;  // token present in this stage
    logic free;   // an invalid entry was found
    logic best;   // a candidate is held
  } tok_t;

  // Write command broadcast to every cell.
  typedef struct packed {
    logic upd_stamp;  // matching cell takes the new stamp
    logic upd_ppn;    // matching cell takes the new physical page
    logic fill;       // cell selected by fill_idx is (re)written
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/tlb_cell.sv =====
// One translation entry with its match logic and one stage of the victim-search chain.
`timescale 1ns / 1ps
`default_nettype none
module tlb_cell #(
  parameter int ENTRIES   = tlb_pkg::ENTRIES_DEF,
  parameter int PAGE_BITS = tlb_pkg::PAGE_BITS_DEF,
  parameter int MY_IDX    = 0,
  localparam int IDX_BITS = $clog2(ENTRIES)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [PAGE_BITS-1:0]            vpn_in,
  input  logic [PAGE_BITS-1:0]            ppn_in,
  input  logic [tlb_pkg::STAMP_BITS-1:0]  stamp_in,
  input  tlb_pkg::cmd_t                   cmd,
  input  logic [IDX_BITS-1:0]             fill_idx,
  output logic                            match,
  output logic [PAGE_BITS-1:0]            ppn_hit,
  input  tlb_pkg::tok_t                   tok_in,
  input  logic [IDX_BITS-1:0]             tok_idx_in,
  input  logic [tlb_pkg::STAMP_BITS-1:0]  tok_stamp_in,
  output tlb_pkg::tok_t                   tok_out,
  output logic [IDX_BITS-1:0]             tok_idx_out,
  output logic [tlb_pkg::STAMP_BITS-1:0]  tok_stamp_out
);

  logic                           valid;
  logic [PAGE_BITS-1:0]           vpn;
  logic [PAGE_BITS-1:0]           ppn;
  logic [tlb_pkg::STAMP_BITS-1:0] stamp;

  tlb_pkg::tok_t                  tok_next;
  logic [IDX_BITS-1:0]            tok_idx_next;
  logic [tlb_pkg::STAMP_BITS-1:0] tok_stamp_next;
  logic                           fill_me;

  assign match   = valid && (vpn == vpn_in);
  assign ppn_hit = match ? ppn : '0;
  assign fill_me = cmd.fill && (fill_idx == IDX_BITS'(MY_IDX));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (fill_me) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_me) begin
      vpn   <= vpn_in;
      ppn   <= ppn_in;
      stamp <= stamp_in;
    end else begin
      if (match && cmd.upd_ppn) begin
        ppn <= ppn_in;
      end
      if (match && cmd.upd_stamp) begin
        stamp <= stamp_in;
      end
    end
  end

  // First free entry wins; otherwise strictly smaller stamp, so ties keep the lower index.
  always_comb begin
    tok_next       = tok_in;
    tok_idx_next   = tok_idx_in;
    tok_stamp_next = tok_stamp_in;
    if (tok_in.valid && !tok_in.free) begin
      if (!valid) begin
        tok_next.free = 1'b1;
        tok_next.best = 1'b1;
        tok_idx_next  = IDX_BITS'(MY_IDX);
      end else if (!tok_in.best || (stamp < tok_stamp_in)) begin
        tok_next.best  = 1'b1;
        tok_idx_next   = IDX_BITS'(MY_IDX);
        tok_stamp_next = stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    tok_idx_out   <= tok_idx_next;
    tok_stamp_out <= tok_stamp_next;
  end

endmodule
`default_nettype wire

// ===== rtl/core/tlb_fully_associative_lru.sv =====
// Top level: fully associative translation buffer with stamp-based LRU replacement.
//
//   channel   signals                                      direction
//   in        in_valid, in_stall, action,                  request words in
//             virtual_page, physical_page
//   out       out_valid, out_stall, hit, physical_page_out lookup results out
//
// Lookup and insert that hits: after the accept the block compares in S_WORK, then returns to S_IDLE.
// Insert that misses: S_WORK starts a scan; the victim token walks the cell chain one
// cell per cycle in S_SCAN, and the chosen entry is filled as the token leaves the chain.
// A lookup result sits in an output register; a stalled result holds the block in its
// compare state (S_WORK) until the register frees up. Reset clears valid bits and the counter.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tlb_fully_associative_lru #(
  parameter int ENTRIES   = tlb_pkg::ENTRIES_DEF,
  parameter int PAGE_BITS = tlb_pkg::PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic [PAGE_BITS-1:0] virtual_page,
  input  logic [PAGE_BITS-1:0] physical_page,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit,
  output logic [PAGE_BITS-1:0] physical_page_out
);

  localparam int IDX_BITS = $clog2(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WORK = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t                         state;
  state_t                         state_next;
  logic                           act;
  logic [PAGE_BITS-1:0]           vpn;
  logic [PAGE_BITS-1:0]           ppn;
  logic [tlb_pkg::STAMP_BITS-1:0] use_counter;
  logic [tlb_pkg::STAMP_BITS-1:0] stamp_new;

  tlb_pkg::cmd_t                  cmd;
  logic [ENTRIES-1:0]             match_vec;
  logic [PAGE_BITS-1:0]           ppn_hit [ENTRIES];
  logic [PAGE_BITS-1:0]           ppn_sel;
  logic                           any_hit;
  logic                           out_free;
  logic                           commit_lookup;
  logic                           start_scan;

  tlb_pkg::tok_t                  tok_w       [ENTRIES+1];
  logic [IDX_BITS-1:0]            tok_idx_w   [ENTRIES+1];
  logic [tlb_pkg::STAMP_BITS-1:0] tok_stamp_w [ENTRIES+1];

  assign in_stall      = (state != S_IDLE);
  assign any_hit       = |match_vec;
  assign out_free      = !out_valid || !out_stall;
  assign commit_lookup = (state == S_WORK) && (act == tlb_pkg::ACT_LOOKUP) && out_free;
  assign start_scan    = (state == S_WORK) && (act == tlb_pkg::ACT_INSERT) && !any_hit;
  assign stamp_new     = use_counter + tlb_pkg::STAMP_BITS'(1);

  assign cmd.upd_stamp = (state == S_WORK) && any_hit
                         && ((act == tlb_pkg::ACT_INSERT) || out_free);
  assign cmd.upd_ppn   = (state == S_WORK) && any_hit && (act == tlb_pkg::ACT_INSERT);
  assign cmd.fill      = (state == S_SCAN) && tok_w[ENTRIES].valid;

  // At most one cell matches, so an OR picks its page.
  always_comb begin
    ppn_sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      ppn_sel = ppn_sel | ppn_hit[i];
    end
  end

  assign tok_w[0].valid = start_scan;
  assign tok_w[0].free  = 1'b0;
  assign tok_w[0].best  = 1'b0;
  assign tok_idx_w[0]   = '0;
  assign tok_stamp_w[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tlb_cell #(
      .ENTRIES   (ENTRIES),
      .PAGE_BITS (PAGE_BITS),
      .MY_IDX    (g)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .vpn_in        (vpn),
      .ppn_in        (ppn),
      .stamp_in      (stamp_new),
      .cmd           (cmd),
      .fill_idx      (tok_idx_w[ENTRIES]),
      .match         (match_vec[g]),
      .ppn_hit       (ppn_hit[g]),
      .tok_in        (tok_w[g]),
      .tok_idx_in    (tok_idx_w[g]),
      .tok_stamp_in  (tok_stamp_w[g]),
      .tok_out       (tok_w[g+1]),
      .tok_idx_out   (tok_idx_w[g+1]),
      .tok_stamp_out (tok_stamp_w[g+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_WORK;
        end
      end
      S_WORK: begin
        if (act == tlb_pkg::ACT_LOOKUP) begin
          if (out_free) begin
            state_next = S_IDLE;
          end
        end else if (any_hit) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok_w[ENTRIES].valid) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      act <= action;
      vpn <= virtual_page;
      ppn <= physical_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_counter <= '0;
    end else if (cmd.upd_stamp || cmd.fill) begin
      use_counter <= stamp_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit_lookup) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_lookup) begin
      hit               <= any_hit;
      physical_page_out <= ppn_sel;
    end
  end

  `ASSERT_CLK(a_match_onehot, $onehot0(match_vec), "more than one entry matches")
  `ASSERT_IMPL(a_tok_in_scan, tok_w[ENTRIES].valid, state == S_SCAN,
               "victim token left the chain outside a scan")
  `ASSERT_NEXT(a_miss_keeps_counter,
               state == S_WORK && act == tlb_pkg::ACT_LOOKUP && !any_hit,
               $stable(use_counter), "lookup miss changed the use counter")
  `ASSERT_IMPL(a_fill_has_slot, cmd.fill, tok_w[ENTRIES].best,
               "fill without a chosen entry")

endmodule
`default_nettype wire

// ===== dv/tlb_translation_check.sv =====
// Translation buffer checker: shadow LRU table, lookup result queue and compare.
`timescale 1ns / 1ps
module tlb_translation_check #(
  parameter int ENTRIES   = tlb_pkg::ENTRIES_DEF,
  parameter int PAGE_BITS = tlb_pkg::PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 action,
  input  logic [PAGE_BITS-1:0] virtual_page,
  input  logic [PAGE_BITS-1:0] physical_page,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 hit,
  input  logic [PAGE_BITS-1:0] physical_page_out,
  output int                   errors,
  output int                   pending
);

  typedef struct packed {
    logic                 hit;
    logic [PAGE_BITS-1:0] page;
  } lookup_word_t;

  lookup_word_t lookups_due[$];

  logic                          shadow_valid [ENTRIES];
  logic [PAGE_BITS-1:0]          shadow_vpn   [ENTRIES];
  logic [PAGE_BITS-1:0]          shadow_ppn   [ENTRIES];
  logic [tlb_pkg::STAMP_BITS-1:0] shadow_stamp [ENTRIES];
  logic [tlb_pkg::STAMP_BITS-1:0] use_count;

  int fail_count = 0;
  int due_count  = 0;

  assign errors  = fail_count;
  assign pending = due_count;

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    $display("[%0t] MISMATCH %s: want %0h, got %0h", $time, what, want, got);
    fail_count++;
  endtask

  // Applies one accepted request word to the shadow table and queues a lookup's expected result.
  task automatic translate(input logic act, input logic [PAGE_BITS-1:0] vpn,
                           input logic [PAGE_BITS-1:0] ppn);
    int slot;
    lookup_word_t w;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (slot < 0 && shadow_valid[i] && shadow_vpn[i] == vpn) slot = i;
    if (act == tlb_pkg::ACT_LOOKUP) begin
      if (slot >= 0) begin
        use_count = use_count + tlb_pkg::STAMP_BITS'(1);
        shadow_stamp[slot] = use_count;
        w.hit  = 1'b1;
        w.page = shadow_ppn[slot];
      end else begin
        w.hit  = 1'b0;
        w.page = '0;
      end
      lookups_due.push_back(w);
    end else begin
      if (slot < 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && !shadow_valid[i]) slot = i;
        // table full: oldest stamp, lowest index on ties
        if (slot < 0) begin
          slot = 0;
          for (int i = 1; i < ENTRIES; i++)
            if (shadow_stamp[i] < shadow_stamp[slot]) slot = i;
        end
        shadow_vpn[slot]   = vpn;
        shadow_valid[slot] = 1'b1;
      end
      use_count = use_count + tlb_pkg::STAMP_BITS'(1);
      shadow_ppn[slot]   = ppn;
      shadow_stamp[slot] = use_count;
    end
  endtask

  always @(posedge clk) begin
    lookup_word_t w;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) shadow_valid[i] = 1'b0;
      use_count = '0;
      lookups_due.delete();
    end else begin
      // drain the result side first; a word accepted now cannot leave this edge
      if (out_valid && !out_stall) begin
        if (lookups_due.size() == 0) begin
          report("result word with no lookup pending", '0, 64'({hit, physical_page_out}));
        end else begin
          w = lookups_due.pop_front();
          if (hit !== w.hit) report("hit", 64'(w.hit), 64'(hit));
          if (physical_page_out !== w.page)
            report("physical_page_out", 64'(w.page), 64'(physical_page_out));
        end
      end
      if (in_valid && !in_stall) translate(action, virtual_page, physical_page);
    end
    due_count = lookups_due.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Testbench top: clock, reset, request and result stimulus, and the verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int ENTRIES      = tlb_pkg::ENTRIES_DEF;
  localparam int PAGE_BITS    = tlb_pkg::PAGE_BITS_DEF;
  localparam int RANDOM_WORDS = 1340;
  localparam int HOLD_WORDS   = 40;
  localparam int POOL_SIZE    = 24;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic [PAGE_BITS-1:0] PAGE_MAX = '1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 action = tlb_pkg::ACT_LOOKUP;
  logic [PAGE_BITS-1:0] virtual_page = '0;
  logic [PAGE_BITS-1:0] physical_page = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 hit;
  logic [PAGE_BITS-1:0] physical_page_out;

  int errors;
  int pending;
  int cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tlb_fully_associative_lru #(
    .ENTRIES   (ENTRIES),
    .PAGE_BITS (PAGE_BITS)
  ) DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .action            (action),
    .virtual_page      (virtual_page),
    .physical_page     (physical_page),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .hit               (hit),
    .physical_page_out (physical_page_out)
  );

  tlb_translation_check #(
    .ENTRIES   (ENTRIES),
    .PAGE_BITS (PAGE_BITS)
  ) translation_check (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .action            (action),
    .virtual_page      (virtual_page),
    .physical_page     (physical_page),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .hit               (hit),
    .physical_page_out (physical_page_out),
    .errors            (errors),
    .pending           (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d lookups outstanding", cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random stall segments, a long hold on request.
  initial begin : result_side
    int run_left;
    bit stalling;
    run_left = 0;
    stalling = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stalling = 1'b1;
        run_left = 400;
      end else if (run_left == 0) begin
        if (quiet) begin
          stalling = 1'b0;
          run_left = 8;
        end else begin
          stalling = ($urandom_range(0, 2) == 0);
          if (!stalling) run_left = $urandom_range(1, 12);
          else if ($urandom_range(0, 9) == 0) run_left = $urandom_range(20, 50);
          else run_left = $urandom_range(1, 3);
        end
      end
      run_left--;
      out_stall <= stalling;
    end
  end

  task automatic send_word(input logic act, input logic [PAGE_BITS-1:0] vpn,
                           input logic [PAGE_BITS-1:0] ppn);
    @(negedge clk);
    in_valid      <= 1'b1;
    action        <= act;
    virtual_page  <= vpn;
    physical_page <= ppn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic sender_gap();
    int len;
    if (quiet || $urandom_range(0, 2) == 0) len = 0;
    else if ($urandom_range(0, 15) == 0) len = $urandom_range(15, 60);
    else len = $urandom_range(1, 3);
    if (len > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (len - 1) @(negedge clk);
    end
  endtask

  // Stop offering words until every lookup result is back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : request_side
    logic [PAGE_BITS-1:0] vpn_pool [POOL_SIZE];
    logic [PAGE_BITS-1:0] vpn;
    logic                 act;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // empty table, page extremes, update in place
    send_word(tlb_pkg::ACT_LOOKUP, '0, PAGE_MAX);
    send_word(tlb_pkg::ACT_INSERT, '0, PAGE_MAX);
    send_word(tlb_pkg::ACT_INSERT, PAGE_MAX, '0);
    send_word(tlb_pkg::ACT_LOOKUP, '0, '0);
    send_word(tlb_pkg::ACT_LOOKUP, PAGE_MAX, PAGE_MAX);
    send_word(tlb_pkg::ACT_INSERT, '0, PAGE_BITS'('h12345));
    send_word(tlb_pkg::ACT_LOOKUP, '0, PAGE_MAX);
    // fill every free entry, then evict the least recently used one
    for (int i = 1; i <= ENTRIES - 2; i++)
      send_word(tlb_pkg::ACT_INSERT, PAGE_BITS'(i), PAGE_BITS'(i * 'h111));
    send_word(tlb_pkg::ACT_INSERT, PAGE_BITS'('h100), PAGE_BITS'('hABCDE));
    send_word(tlb_pkg::ACT_LOOKUP, PAGE_MAX, '0);
    send_word(tlb_pkg::ACT_LOOKUP, PAGE_BITS'('h100), '0);
    drain();

    // result side holds off while words keep coming, so the input backs up
    hold_req = 1'b1;
    quiet = 1'b1;
    for (int i = 0; i < HOLD_WORDS; i++)
      send_word($urandom_range(0, 3) == 0 ? tlb_pkg::ACT_INSERT : tlb_pkg::ACT_LOOKUP,
                PAGE_BITS'($urandom_range(0, ENTRIES)), PAGE_BITS'($urandom()));
    quiet = 1'b0;
    drain();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // working set a bit larger than the table so hits and evictions both happen
      if (n % 250 == 0)
        for (int k = 0; k < POOL_SIZE; k++) vpn_pool[k] = PAGE_BITS'($urandom());
      quiet = (n % 250 >= 180) && (n % 250 < 220);
      if (n % 300 == 299) drain();
      act = ($urandom_range(0, 99) < 35) ? tlb_pkg::ACT_INSERT : tlb_pkg::ACT_LOOKUP;
      if ($urandom_range(0, 99) < 85) vpn = vpn_pool[$urandom_range(0, POOL_SIZE - 1)];
      else vpn = PAGE_BITS'($urandom());
      send_word(act, vpn, PAGE_BITS'($urandom()));
      sender_gap();
    end
    quiet = 1'b0;

    drain();
    repeat (ENTRIES + 8) @(negedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tlb_pkg.sv
rtl/core/tlb_cell.sv
rtl/core/tlb_fully_associative_lru.sv
dv/tlb_translation_check.sv
dv/testbench.sv
